>>> rtl/tlci_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlci_pkg
// shared types and constants of the text line and column index
// ----------------------------------------------------------------------------
package tlci_pkg;

  localparam int LEN_AW      = 16;
  localparam int LEN_ENTRIES = 1 << LEN_AW;
  localparam int LC_W        = LEN_AW + 1;
  localparam int MRK_AW      = 10;
  localparam int MRK_ENTRIES = 1 << MRK_AW;
  localparam int MC_W        = MRK_AW + 1;
  localparam int LTM_W       = 7;
  localparam int POS_W       = 21;
  localparam int MAX_TEXT_CHARS = 1 << 20;

  localparam logic [LTM_W-1:0] MARKER_SPACING = 7'd100;
  localparam logic [7:0]       LONG_MARK      = 8'd255;
  localparam logic [7:0]       LONG_SPAN      = 8'd254;
  localparam logic [7:0]       NEWLINE        = 8'd10;

  typedef enum logic [2:0] {
    REQ_BYTE  = 3'd0,
    REQ_EOT   = 3'd1,
    REQ_LINE  = 3'd2,
    REQ_OFFS  = 3'd3,
    REQ_CLEAR = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_BUILT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_MARK, S_WRD, S_WSTEP, S_TRD, S_TSTEP
  } state_e;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_ACCEPT, CMD_SRCH, CMD_MARK, CMD_WALK, CMD_TAIL
  } cmd_e;

  typedef struct packed {
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] line;
    logic [LC_W-1:0]  entry;
  } mrk_t;

  typedef struct packed {
    cmd_e op;
  } ctl_t;

  typedef struct packed {
    logic start_query;
    logic out_busy;
    logic srch_done;
    logic walk_more;
    logic is_line;
    logic tail_more;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/tlci_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlci_req_if
// request channel: text bytes, end of text, queries and clear
// ----------------------------------------------------------------------------
interface tlci_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  text_byte;
  logic [20:0] line_number;
  logic [20:0] column;
  logic [20:0] char_offset;

  modport source(output valid, req_type, text_byte, line_number, column, char_offset,
                 input ready);
  modport sink(input valid, req_type, text_byte, line_number, column, char_offset,
               output ready);
endinterface
`default_nettype wire

>>> rtl/tlci_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlci_rsp_if
// result channel: one item per request
// ----------------------------------------------------------------------------
interface tlci_rsp_if;
  logic        valid;
  logic        ready;
  logic [20:0] offset_out;
  logic [20:0] line_out;
  logic [20:0] col_out;
  logic        truncated;
  logic [1:0]  status;

  modport source(output valid, offset_out, line_out, col_out, truncated, status,
                 input ready);
  modport sink(input valid, offset_out, line_out, col_out, truncated, status,
               output ready);
endinterface
`default_nettype wire

>>> rtl/tlci_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlci_ctrl
// sequencer for marker search, line walk and column tail walk
// ----------------------------------------------------------------------------
module tlci_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tlci_pkg::sts_t sts_i,
  output tlci_pkg::ctl_t ctl_o
);

  tlci_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlci_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o.op   = tlci_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      tlci_pkg::S_IDLE: begin
        in_ready_o = !sts_i.out_busy;
        if (in_valid_i && !sts_i.out_busy) begin
          ctl_o.op = tlci_pkg::CMD_ACCEPT;
          if (sts_i.start_query) state_d = tlci_pkg::S_RD;
        end
      end
      tlci_pkg::S_RD: begin
        state_d = sts_i.srch_done ? tlci_pkg::S_MARK : tlci_pkg::S_CMP;
      end
      tlci_pkg::S_CMP: begin
        ctl_o.op = tlci_pkg::CMD_SRCH;
        state_d  = tlci_pkg::S_RD;
      end
      tlci_pkg::S_MARK: begin
        ctl_o.op = tlci_pkg::CMD_MARK;
        state_d  = tlci_pkg::S_WRD;
      end
      tlci_pkg::S_WRD: begin
        state_d = tlci_pkg::S_WSTEP;
      end
      tlci_pkg::S_WSTEP: begin
        ctl_o.op = tlci_pkg::CMD_WALK;
        if (sts_i.walk_more) state_d = tlci_pkg::S_WRD;
        else if (sts_i.is_line) state_d = tlci_pkg::S_TRD;
        else state_d = tlci_pkg::S_IDLE;
      end
      tlci_pkg::S_TRD: begin
        state_d = tlci_pkg::S_TSTEP;
      end
      tlci_pkg::S_TSTEP: begin
        ctl_o.op = tlci_pkg::CMD_TAIL;
        state_d  = sts_i.tail_more ? tlci_pkg::S_TRD : tlci_pkg::S_IDLE;
      end
      default: state_d = tlci_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/tlci_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlci_dp
// index tables, build counters, query registers and result register
// ----------------------------------------------------------------------------
module tlci_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tlci_pkg::ctl_t ctl_i,
  output tlci_pkg::sts_t sts_o,
  input  logic [2:0]     req_type_i,
  input  logic [7:0]     text_byte_i,
  input  logic [20:0]    line_number_i,
  input  logic [20:0]    column_i,
  input  logic [20:0]    char_offset_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [20:0]    offset_out_o,
  output logic [20:0]    line_out_o,
  output logic [20:0]    col_out_o,
  output logic           truncated_o,
  output logic [1:0]     status_o
);

  localparam int PW = tlci_pkg::POS_W;
  localparam int LW = tlci_pkg::LC_W;
  localparam int MW = tlci_pkg::MC_W;
  localparam int AW = tlci_pkg::MRK_AW;
  localparam logic [tlci_pkg::LTM_W-1:0] LTM_ONE = {{(tlci_pkg::LTM_W-1){1'b0}}, 1'b1};

  // index memories
  logic [7:0]    len_mem [tlci_pkg::LEN_ENTRIES];
  tlci_pkg::mrk_t mrk_mem [tlci_pkg::MRK_ENTRIES];
  logic                      len_we;
  logic [tlci_pkg::LEN_AW-1:0] len_waddr;
  logic [7:0]                len_wdata;
  logic [7:0]                len_rd_q;
  logic                      mrk_we;
  tlci_pkg::mrk_t            mrk_wdata;
  logic [AW-1:0]             mrk_raddr;
  tlci_pkg::mrk_t            mrk_rd_q;
  logic                      rdzero_q;

  // build state
  logic [LW-1:0]   lc_q, lc_d;
  logic [MW-1:0]   mc_q, mc_d;
  logic [PW-1:0]   tc_q, tc_d;
  logic [PW-1:0]   tl_q, tl_d;
  logic [7:0]      rll_q, rll_d;
  logic [tlci_pkg::LTM_W-1:0] ltm_q, ltm_d;
  logic            built_q, built_d;
  logic            ovf_q, ovf_d;
  logic [PW-1:0]   cur_off_q, cur_off_d;
  logic [PW-1:0]   cur_line_q, cur_line_d;
  logic [LW-1:0]   cur_idx_q, cur_idx_d;
  logic [PW-1:0]   cur_col_q, cur_col_d;

  // query state
  logic            is_line_q, is_line_d;
  logic [PW-1:0]   want_q, want_d;
  logic [PW-1:0]   c_q, c_d;
  logic [AW-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [PW-1:0]   ln_q, ln_d;
  logic [LW-1:0]   idx_q, idx_d;
  logic [PW-1:0]   qcol_q, qcol_d;
  logic [PW-1:0]   res_q, res_d;

  // result register
  logic            ov_q, ov_d;
  logic [PW-1:0]   o_off_q, o_off_d, o_line_q, o_line_d, o_col_q, o_col_d;
  logic            o_tr_q, o_tr_d;
  tlci_pkg::status_e o_st_q, o_st_d;

  logic [AW:0]     mid_sum;
  logic [AW-1:0]   mid;
  logic            srch_done;
  tlci_pkg::mrk_t  mrk_eff;
  logic [PW-1:0]   key;
  logic            lc_full;
  logic            idx_ok;
  logic            walk_more;
  logic            tail_more;
  logic            start;
  logic [PW:0]     pos_v;

  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q} + {{AW{1'b0}}, 1'b1};
  assign mid       = mid_sum[AW:1];
  assign srch_done = lo_q >= hi_q;
  assign mrk_raddr = srch_done ? lo_q : mid;
  assign mrk_eff   = rdzero_q ? tlci_pkg::mrk_t'{off: '0, line: PW'(1), entry: '0}
                              : mrk_rd_q;
  assign key       = is_line_q ? mrk_eff.line : mrk_eff.off;
  assign lc_full   = lc_q >= LW'(tlci_pkg::LEN_ENTRIES);
  assign idx_ok    = idx_q < lc_q;
  assign pos_v     = {1'b0, pos_q} + {{(PW-7){1'b0}}, len_rd_q};
  assign walk_more = is_line_q ? ((ln_q < want_q) && idx_ok)
                               : (idx_ok && (pos_v < {1'b0, want_q}));
  assign tail_more = idx_ok && (c_q > {{(PW-8){1'b0}}, len_rd_q})
                     && (len_rd_q == tlci_pkg::LONG_MARK);

  always_comb begin
    start = 1'b0;
    if (!ovf_q && built_q) begin
      if (req_type_i == tlci_pkg::REQ_LINE) begin
        start = !((line_number_i == '0) || ({1'b0, line_number_i} > ({1'b0, tl_q} + 1'b1))
                  || (column_i == '0));
      end else if (req_type_i == tlci_pkg::REQ_OFFS) begin
        start = !(char_offset_i > tc_q);
      end
    end
  end

  assign sts_o.start_query = start;
  assign sts_o.out_busy    = ov_q && !out_ready_i;
  assign sts_o.srch_done   = srch_done;
  assign sts_o.walk_more   = walk_more;
  assign sts_o.is_line     = is_line_q;
  assign sts_o.tail_more   = tail_more;

  always_ff @(posedge clk_i) begin
    if (len_we) len_mem[len_waddr] <= len_wdata;
    len_rd_q <= len_mem[idx_q[tlci_pkg::LEN_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (mrk_we) mrk_mem[mc_q[AW-1:0]] <= mrk_wdata;
    mrk_rd_q <= mrk_mem[mrk_raddr];
    rdzero_q <= mrk_raddr == '0;
  end

  always_comb begin
    lc_d = lc_q; mc_d = mc_q; tc_d = tc_q; tl_d = tl_q; rll_d = rll_q; ltm_d = ltm_q;
    built_d = built_q; ovf_d = ovf_q;
    cur_off_d = cur_off_q; cur_line_d = cur_line_q; cur_idx_d = cur_idx_q;
    cur_col_d = cur_col_q;
    is_line_d = is_line_q; want_d = want_q; c_d = c_q; lo_d = lo_q; hi_d = hi_q;
    pos_d = pos_q; ln_d = ln_q; idx_d = idx_q; qcol_d = qcol_q; res_d = res_q;
    ov_d = ov_q && !out_ready_i;
    o_off_d = o_off_q; o_line_d = o_line_q; o_col_d = o_col_q; o_tr_d = o_tr_q;
    o_st_d = o_st_q;
    len_we = 1'b0; len_waddr = lc_q[tlci_pkg::LEN_AW-1:0]; len_wdata = rll_q;
    mrk_we = 1'b0;
    mrk_wdata = '{off: tc_q + 1'b1, line: tl_q + PW'(2), entry: lc_q + 1'b1};

    case (ctl_i.op)
      tlci_pkg::CMD_ACCEPT: begin
        o_off_d = '0; o_line_d = '0; o_col_d = '0; o_tr_d = 1'b0;
        o_st_d = tlci_pkg::ST_OK;
        ov_d = !start;
        if (req_type_i == tlci_pkg::REQ_CLEAR) begin
          lc_d = '0; mc_d = MW'(1); tc_d = '0; tl_d = '0; rll_d = '0;
          ltm_d = tlci_pkg::MARKER_SPACING; built_d = 1'b0; ovf_d = 1'b0;
          cur_off_d = '0; cur_line_d = PW'(1); cur_idx_d = '0; cur_col_d = PW'(1);
        end else if (req_type_i > tlci_pkg::REQ_CLEAR) begin
          o_st_d = tlci_pkg::ST_RANGE;
        end else if (ovf_q) begin
          if (req_type_i == tlci_pkg::REQ_EOT) built_d = 1'b1;
          o_st_d = tlci_pkg::ST_FULL;
        end else if (req_type_i == tlci_pkg::REQ_BYTE || req_type_i == tlci_pkg::REQ_EOT) begin
          if (built_q) begin
            o_st_d = tlci_pkg::ST_RANGE;
          end else if (req_type_i == tlci_pkg::REQ_EOT) begin
            if (lc_full) ovf_d = 1'b1;
            else begin
              len_we = 1'b1; lc_d = lc_q + 1'b1;
            end
            rll_d = '0;
            built_d = 1'b1;
            if (lc_full) o_st_d = tlci_pkg::ST_FULL;
          end else if (tc_q >= PW'(tlci_pkg::MAX_TEXT_CHARS)) begin
            ovf_d = 1'b1;
            o_st_d = tlci_pkg::ST_FULL;
          end else begin
            tc_d = tc_q + 1'b1;
            if (text_byte_i != tlci_pkg::NEWLINE) begin
              if (rll_q == tlci_pkg::LONG_MARK - 1'b1) begin
                len_wdata = tlci_pkg::LONG_MARK;
                rll_d = 8'd1;
                if (lc_full) ovf_d = 1'b1;
                else begin
                  len_we = 1'b1; lc_d = lc_q + 1'b1;
                end
              end else begin
                rll_d = rll_q + 1'b1;
              end
            end else begin
              rll_d = '0;
              tl_d = tl_q + 1'b1;
              if (lc_full) ovf_d = 1'b1;
              else begin
                len_we = 1'b1; lc_d = lc_q + 1'b1;
                if (ltm_q == LTM_ONE) begin
                  ltm_d = tlci_pkg::MARKER_SPACING;
                  if (mc_q < MW'(tlci_pkg::MRK_ENTRIES)) begin
                    mrk_we = 1'b1; mc_d = mc_q + 1'b1;
                  end
                end else begin
                  ltm_d = ltm_q - 1'b1;
                end
              end
            end
            if (ovf_d) o_st_d = tlci_pkg::ST_FULL;
          end
        end else if (!built_q) begin
          o_st_d = tlci_pkg::ST_NOT_BUILT;
        end else if (!start) begin
          o_st_d = tlci_pkg::ST_RANGE;
        end else begin
          is_line_d = req_type_i == tlci_pkg::REQ_LINE;
          want_d = is_line_d ? line_number_i : char_offset_i;
          c_d = column_i - 1'b1;
          lo_d = '0;
          hi_d = AW'(mc_q - 1'b1);
        end
      end
      tlci_pkg::CMD_SRCH: begin
        if (key > want_q) hi_d = mid - 1'b1;
        else lo_d = mid;
      end
      tlci_pkg::CMD_MARK: begin
        pos_d = mrk_eff.off; ln_d = mrk_eff.line; idx_d = mrk_eff.entry;
        qcol_d = PW'(1);
        if (is_line_q) begin
          if (cur_col_q == PW'(1) && cur_line_q >= mrk_eff.line && cur_line_q <= want_q) begin
            pos_d = cur_off_q; ln_d = cur_line_q; idx_d = cur_idx_q;
          end
        end else if (cur_off_q >= mrk_eff.off && cur_off_q <= want_q) begin
          pos_d = cur_off_q; ln_d = cur_line_q; idx_d = cur_idx_q; qcol_d = cur_col_q;
        end
      end
      tlci_pkg::CMD_WALK: begin
        if (walk_more) begin
          if (len_rd_q != tlci_pkg::LONG_MARK) begin
            pos_d = pos_q + PW'(len_rd_q) + 1'b1; ln_d = ln_q + 1'b1; qcol_d = PW'(1);
          end else begin
            pos_d = pos_q + PW'(tlci_pkg::LONG_SPAN);
            qcol_d = qcol_q + PW'(tlci_pkg::LONG_SPAN);
          end
          idx_d = idx_q + 1'b1;
        end else begin
          cur_off_d = pos_q; cur_line_d = ln_q; cur_idx_d = idx_q;
          cur_col_d = is_line_q ? PW'(1) : qcol_q;
          if (is_line_q) begin
            res_d = pos_q;
          end else begin
            ov_d = 1'b1;
            o_line_d = ln_q;
            o_col_d = qcol_q + (want_q - pos_q);
          end
        end
      end
      tlci_pkg::CMD_TAIL: begin
        if (tail_more) begin
          c_d = c_q - PW'(tlci_pkg::LONG_SPAN);
          pos_d = pos_q + PW'(tlci_pkg::LONG_SPAN);
          idx_d = idx_q + 1'b1;
          res_d = pos_d;
        end else begin
          ov_d = 1'b1;
          o_off_d = res_q; o_tr_d = 1'b1;
          if (idx_ok) begin
            if (c_q <= PW'(len_rd_q)) begin
              o_off_d = pos_q + c_q; o_tr_d = 1'b0;
            end else begin
              o_off_d = pos_q + PW'(len_rd_q);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q <= '0; mc_q <= MW'(1); tc_q <= '0; tl_q <= '0; rll_q <= '0;
      ltm_q <= tlci_pkg::MARKER_SPACING; built_q <= 1'b0; ovf_q <= 1'b0;
      cur_off_q <= '0; cur_line_q <= PW'(1); cur_idx_q <= '0; cur_col_q <= PW'(1);
      lo_q <= '0; hi_q <= '0; idx_q <= '0;
      ov_q <= 1'b0;
    end else begin
      lc_q <= lc_d; mc_q <= mc_d; tc_q <= tc_d; tl_q <= tl_d; rll_q <= rll_d;
      ltm_q <= ltm_d; built_q <= built_d; ovf_q <= ovf_d;
      cur_off_q <= cur_off_d; cur_line_q <= cur_line_d; cur_idx_q <= cur_idx_d;
      cur_col_q <= cur_col_d;
      lo_q <= lo_d; hi_q <= hi_d; idx_q <= idx_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_line_q <= is_line_d; want_q <= want_d; c_q <= c_d;
    pos_q <= pos_d; ln_q <= ln_d; qcol_q <= qcol_d; res_q <= res_d;
    o_off_q <= o_off_d; o_line_q <= o_line_d; o_col_q <= o_col_d; o_tr_q <= o_tr_d;
    o_st_q <= o_st_d;
  end

  assign out_valid_o  = ov_q;
  assign offset_out_o = o_off_q;
  assign line_out_o   = o_line_q;
  assign col_out_o    = o_col_q;
  assign truncated_o  = o_tr_q;
  assign status_o     = o_st_q;

endmodule
`default_nettype wire

>>> rtl/text_line_column_index_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_line_column_index_top
// line index over a text byte stream with line/column and offset queries
// ----------------------------------------------------------------------------
// usage:
//   req_i carries text bytes, end of text, queries and clear; rsp_o returns
//   exactly one item per request, in order, through a result register.
//   text bytes, end of text, clear and rejected requests are taken one per
//   cycle while rsp_o does not stall and answered in the next cycle; a new
//   one is taken while the result register is being emptied.
//   a query runs a binary search over the sparse markers, loads the marker,
//   then walks the length entries; every step waits on the registered read
//   of the length memory. a line query then walks the entries of its tail.
//   the kept cursor shortens walks for nearby repeat queries.
//   no new request is taken while a query is in work.
//   reset empties the index; the tables need no clearing pass.
//   when rsp_o is stalled the result holds and req_i stays blocked until the
//   result register is free.
// ----------------------------------------------------------------------------
module text_line_column_index_top (
  input logic        clk_i,
  input logic        rst_ni,
  tlci_req_if.sink   req_i,
  tlci_rsp_if.source rsp_o
);

  tlci_pkg::ctl_t ctl;
  tlci_pkg::sts_t sts;

  tlci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  tlci_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .req_type_i    (req_i.req_type),
    .text_byte_i   (req_i.text_byte),
    .line_number_i (req_i.line_number),
    .column_i      (req_i.column),
    .char_offset_i (req_i.char_offset),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .offset_out_o  (rsp_o.offset_out),
    .line_out_o    (rsp_o.line_out),
    .col_out_o     (rsp_o.col_out),
    .truncated_o   (rsp_o.truncated),
    .status_o      (rsp_o.status)
  );

endmodule
`default_nettype wire
